// ===== hdl/skc_pkg.sv =====
// Shared types, constants and register codes for the skin pixel classifier.
// No dependencies; skc_front, skc_div, skc_norm and skin_pixel_classifier import this package.
package skc_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int LANES         = 2;

  localparam int CHAN_W        = 8;
  localparam int SUM_W         = 10;
  localparam int DEN_W         = SUM_W + 1;
  localparam int MEAN_W        = 16;
  localparam int INV_DEV_W     = 16;
  localparam int DIST_W        = 24;
  localparam int SQ_W          = DIST_W / 2;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 24;

  // Cb/Cr weights in thousandths
  localparam int W_CB_R = 169;
  localparam int W_CB_G = 332;
  localparam int W_CB_B = 500;
  localparam int W_CR_R = 500;
  localparam int W_CR_G = 419;
  localparam int W_CR_B = 81;

  // 2000 = 125 * 2^4: round-to-nearest of sum/1000 becomes floor((sum*2^(F-3) + 62) / 125)
  localparam int MILLI_DIV   = 125;
  localparam int MILLI_BITS  = 7;
  localparam int MILLI_SHIFT = 3;
  localparam int MILLI_BIAS  = 1000 / 16;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP = 4;

  localparam logic [CHAN_W-1:0] TRUTH_MIN = 8'd5;
  localparam logic [DIST_W-1:0] DIST_MAX  = 24'hFF_FFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COLOR_MODE     = 3'd0,
    CFG_MEAN_FIRST     = 3'd1,
    CFG_MEAN_SECOND    = 3'd2,
    CFG_INV_DEV_FIRST  = 3'd3,
    CFG_INV_DEV_SECOND = 3'd4,
    CFG_DISTANCE_LIMIT = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] reference_red;
  } pixel_t;

  typedef struct packed {
    logic              is_skin;
    logic              false_positive;
    logic              false_negative;
    logic [DIST_W-1:0] distance;
  } result_t;

  typedef struct packed {
    logic                     color_mode;
    logic signed [MEAN_W-1:0] mean_first;
    logic signed [MEAN_W-1:0] mean_second;
    logic [INV_DEV_W-1:0]     inv_dev_first;
    logic [INV_DEV_W-1:0]     inv_dev_second;
    logic [DIST_W-1:0]        distance_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    color_mode:     1'b1,
    mean_first:     16'sd0,
    mean_second:    16'sd0,
    inv_dev_first:  16'd256,
    inv_dev_second: 16'd256,
    distance_limit: 24'd30966
  };

endpackage

// ===== hdl/skc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is set at instantiation; no other dependencies.
interface skc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/skc_front.sv =====
// Input stage: Cb/Cr weighted sums biased for the reciprocal divide,
// ratio numerators and divisor. Depends on skc_pkg and skc_stream_if.
module skc_front
  import skc_pkg::*;
#(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int ZW        = FRAC_BITS + 15,
  localparam int NW        = FRAC_BITS + 10
) (
  input  logic                        clk,
  input  logic                        rst,
  skc_stream_if.sink                  pixel,
  output logic                        down_valid,
  input  logic                        down_ready,
  output logic [LANES-1:0][ZW-1:0]    down_z,
  output logic [LANES-1:0][NW-1:0]    down_num,
  output logic [DEN_W-1:0]            down_den,
  output logic                        down_zero,
  output logic                        down_truth
);

  localparam int MILLI_W = 19;
  localparam logic signed [ZW:0] Z_BIAS =
    ((ZW + 1)'(MILLI_DIV) <<< (FRAC_BITS + 7)) + (ZW + 1)'(MILLI_BIAS);

  logic                      adv;
  logic signed [MILLI_W-1:0] r_s, g_s, b_s;
  logic signed [MILLI_W-1:0] m_first, m_second;
  logic signed [ZW:0]        zw_first, zw_second;
  logic [SUM_W-1:0]          sum;

  assign adv         = !down_valid || down_ready;
  assign pixel.ready = adv;

  always_comb begin
    r_s       = signed'(MILLI_W'(pixel.data.red));
    g_s       = signed'(MILLI_W'(pixel.data.green));
    b_s       = signed'(MILLI_W'(pixel.data.blue));
    m_first   = MILLI_W'(W_CB_B) * b_s - MILLI_W'(W_CB_R) * r_s - MILLI_W'(W_CB_G) * g_s;
    m_second  = MILLI_W'(W_CR_R) * r_s - MILLI_W'(W_CR_G) * g_s - MILLI_W'(W_CR_B) * b_s;
    zw_first  = ((ZW + 1)'(m_first) <<< (FRAC_BITS - MILLI_SHIFT)) + Z_BIAS;
    zw_second = ((ZW + 1)'(m_second) <<< (FRAC_BITS - MILLI_SHIFT)) + Z_BIAS;
    sum       = SUM_W'(pixel.data.red) + SUM_W'(pixel.data.green) + SUM_W'(pixel.data.blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (adv) begin
      down_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      down_z[0]   <= zw_first[ZW-1:0];
      down_z[1]   <= zw_second[ZW-1:0];
      down_num[0] <= (NW'(pixel.data.red) << (FRAC_BITS + 1)) + NW'(sum);
      down_num[1] <= (NW'(pixel.data.green) << (FRAC_BITS + 1)) + NW'(sum);
      down_den    <= {sum, 1'b0};
      down_zero   <= (sum == '0);
      down_truth  <= (pixel.data.reference_red > TRUTH_MIN);
    end
  end

endmodule

// ===== hdl/skc_div.sv =====
// Divider pipeline: restoring division for the chromatic ratios, a few
// quotient bits per stage, plus the reciprocal divide by 125. Depends on skc_pkg.
module skc_div
  import skc_pkg::*;
#(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int ZW        = FRAC_BITS + 15,
  localparam int NW        = FRAC_BITS + 10,
  localparam int QW        = FRAC_BITS + 1,
  localparam int QMW       = FRAC_BITS + 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [LANES-1:0][ZW-1:0]    up_z,
  input  logic [LANES-1:0][NW-1:0]    up_num,
  input  logic [DEN_W-1:0]            up_den,
  input  logic                        up_zero,
  input  logic                        up_truth,
  output logic                        down_valid,
  input  logic                        down_ready,
  output logic [LANES-1:0][QMW-1:0]   down_q_milli,
  output logic [LANES-1:0][QW-1:0]    down_q_ratio,
  output logic                        down_zero,
  output logic                        down_truth
);

  localparam int DS          = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int RW          = DEN_W;
  localparam int MW          = ZW + 1;
  localparam int PW          = ZW + MW;
  localparam int RECIP_SHIFT = ZW + MILLI_BITS;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << RECIP_SHIFT) + 64'(MILLI_DIV - 1)) / 64'(MILLI_DIV));

  logic [DS:0]                            adv;
  logic [DS-1:0]                          v;
  logic [DS-1:0][LANES-1:0][RW-1:0]       rem_q;
  logic [DS-1:0][LANES-1:0][QW-1:0]       quo_q;
  logic [DS-1:0][LANES-1:0][QMW-1:0]      qm_q;
  logic [DS-1:0][DEN_W-1:0]               den_q;
  logic [DS-1:0]                          zero_q;
  logic [DS-1:0]                          truth_q;

  assign adv[DS]   = down_ready;
  assign up_ready  = adv[0];

  for (genvar s = 0; s < DS; s++) begin : g_stage
    localparam int LEFT  = QW - DIV_STEP * s;
    localparam int STEPS = (LEFT < DIV_STEP) ? LEFT : DIV_STEP;

    logic                          v_in;
    logic [LANES-1:0][RW-1:0]      rem_in, rem_out;
    logic [LANES-1:0][QW-1:0]      quo_in, quo_out;
    logic [LANES-1:0][QMW-1:0]     qm_in;
    logic [DEN_W-1:0]              den_in;
    logic                          zero_in, truth_in;

    assign adv[s] = !v[s] || adv[s+1];

    if (s == 0) begin : g_head
      always_comb begin
        v_in     = up_valid;
        den_in   = up_den;
        zero_in  = up_zero;
        truth_in = up_truth;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = RW'(up_num[l][NW-1:QW]);
          quo_in[l] = up_num[l][QW-1:0];
          qm_in[l]  = QMW'((PW'(up_z[l]) * PW'(RECIP)) >> RECIP_SHIFT);
        end
      end
    end else begin : g_body
      always_comb begin
        v_in     = v[s-1];
        den_in   = den_q[s-1];
        zero_in  = zero_q[s-1];
        truth_in = truth_q[s-1];
        rem_in   = rem_q[s-1];
        quo_in   = quo_q[s-1];
        qm_in    = qm_q[s-1];
      end
    end

    always_comb begin
      logic [RW:0]   t;
      logic [RW-1:0] r;
      logic [QW-1:0] w;
      logic          qbit;
      t    = '0;
      qbit = 1'b0;
      for (int l = 0; l < LANES; l++) begin
        r = rem_in[l];
        w = quo_in[l];
        for (int k = 0; k < STEPS; k++) begin
          t    = {r, w[QW-1]};
          qbit = (t >= {1'b0, den_in});
          if (qbit) begin
            t = t - {1'b0, den_in};
          end
          r = t[RW-1:0];
          w = {w[QW-2:0], qbit};
        end
        rem_out[l] = r;
        quo_out[l] = w;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv[s]) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        rem_q[s]   <= rem_out;
        quo_q[s]   <= quo_out;
        qm_q[s]    <= qm_in;
        den_q[s]   <= den_in;
        zero_q[s]  <= zero_in;
        truth_q[s] <= truth_in;
      end
    end
  end

  assign down_valid   = v[DS-1];
  assign down_q_milli = qm_q[DS-1];
  assign down_q_ratio = quo_q[DS-1];
  assign down_zero    = zero_q[DS-1];
  assign down_truth   = truth_q[DS-1];

endmodule

// ===== hdl/skc_norm.sv =====
// Back end: mean removal, scaling by reciprocal deviation, rounding, squares,
// saturated distance and threshold test. Depends on skc_pkg and skc_stream_if.
module skc_norm
  import skc_pkg::*;
#(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int QW        = FRAC_BITS + 1,
  localparam int QMW       = FRAC_BITS + 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cfg_t                        cfg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [LANES-1:0][QMW-1:0]   up_q_milli,
  input  logic [LANES-1:0][QW-1:0]    up_q_ratio,
  input  logic                        up_zero,
  input  logic                        up_truth,
  skc_stream_if.source                result
);

  localparam int CW = FRAC_BITS + 9;
  localparam int DW = ((CW > MEAN_W) ? CW : MEAN_W) + 1;
  localparam int PW = DW + INV_DEV_W;
  localparam logic [CW-1:0] MILLI_K    = CW'(1) << (FRAC_BITS + 7);
  localparam logic [PW:0]   ROUND_HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

  logic adv1, adv2, adv3, adv4;
  logic v1, v2, v3;
  logic t1, t2, t3;

  logic [LANES-1:0][DW-1:0]     mag_d, mag1;
  logic [LANES-1:0][PW-1:0]     prod_d, prod2;
  logic [LANES-1:0][DIST_W-1:0] sq_d, sq3;
  logic [LANES-1:0]             big_d, big3;
  logic [DIST_W:0]              total;
  logic [DIST_W-1:0]            dist_sat;
  logic                         skin;

  assign adv4     = !result.valid || result.ready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign up_ready = adv1;

  always_comb begin
    logic signed [CW-1:0]     c;
    logic signed [DW-1:0]     diff;
    logic signed [MEAN_W-1:0] mean_l;
    for (int l = 0; l < LANES; l++) begin
      mean_l = (l == 0) ? cfg.mean_first : cfg.mean_second;
      if (cfg.color_mode) begin
        c = signed'(CW'(up_q_milli[l]) - MILLI_K);
      end else if (up_zero) begin
        c = '0;
      end else begin
        c = signed'(CW'(up_q_ratio[l]));
      end
      diff     = DW'(c) - DW'(mean_l);
      mag_d[l] = diff[DW-1] ? DW'(-diff) : DW'(diff);
    end
  end

  always_comb begin
    logic [INV_DEV_W-1:0] inv_l;
    for (int l = 0; l < LANES; l++) begin
      inv_l     = (l == 0) ? cfg.inv_dev_first : cfg.inv_dev_second;
      prod_d[l] = PW'(mag1[l]) * PW'(inv_l);
    end
  end

  always_comb begin
    logic [PW:0]           rnd;
    logic [PW-FRAC_BITS:0] n;
    for (int l = 0; l < LANES; l++) begin
      rnd      = (PW + 1)'(prod2[l]) + ROUND_HALF;
      n        = rnd[PW:FRAC_BITS];
      big_d[l] = |n[PW-FRAC_BITS:SQ_W];
      sq_d[l]  = DIST_W'(n[SQ_W-1:0]) * DIST_W'(n[SQ_W-1:0]);
    end
  end

  always_comb begin
    total    = (DIST_W + 1)'(sq3[0]) + (DIST_W + 1)'(sq3[1]);
    dist_sat = (|big3 || total[DIST_W]) ? DIST_MAX : total[DIST_W-1:0];
    skin     = (dist_sat < cfg.distance_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= up_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv4) begin
        result.valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mag1 <= mag_d;
      t1   <= up_truth;
    end
    if (adv2) begin
      prod2 <= prod_d;
      t2    <= t1;
    end
    if (adv3) begin
      sq3  <= sq_d;
      big3 <= big_d;
      t3   <= t2;
    end
    if (adv4) begin
      result.data.is_skin        <= skin;
      result.data.false_positive <= skin && !t3;
      result.data.false_negative <= !skin && t3;
      result.data.distance       <= dist_sat;
    end
  end

endmodule

// ===== hdl/skin_pixel_classifier.sv =====
// Skin pixel classifier; its restoring divider resolves four ratio quotient bits per stage.
// Throughput one pixel per clock; stalls hold every stage and bubbles are squeezed out.
// Synchronous reset clears all valid bits and loads the register reset values.
// Depends on skc_pkg, skc_stream_if, skc_front, skc_div and skc_norm.
module skin_pixel_classifier
  import skc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  skc_stream_if.sink             pixel,
  skc_stream_if.source           result
);

  localparam int ZW  = FRAC_BITS + 15;
  localparam int NW  = FRAC_BITS + 10;
  localparam int QW  = FRAC_BITS + 1;
  localparam int QMW = FRAC_BITS + 8;

  cfg_t cfg;

  logic                       f_valid, f_ready;
  logic [LANES-1:0][ZW-1:0]   f_z;
  logic [LANES-1:0][NW-1:0]   f_num;
  logic [DEN_W-1:0]           f_den;
  logic                       f_zero, f_truth;

  logic                       d_valid, d_ready;
  logic [LANES-1:0][QMW-1:0]  d_q_milli;
  logic [LANES-1:0][QW-1:0]   d_q_ratio;
  logic                       d_zero, d_truth;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COLOR_MODE:     cfg.color_mode     <= cfg_data[0];
        CFG_MEAN_FIRST:     cfg.mean_first     <= signed'(cfg_data[MEAN_W-1:0]);
        CFG_MEAN_SECOND:    cfg.mean_second    <= signed'(cfg_data[MEAN_W-1:0]);
        CFG_INV_DEV_FIRST:  cfg.inv_dev_first  <= cfg_data[INV_DEV_W-1:0];
        CFG_INV_DEV_SECOND: cfg.inv_dev_second <= cfg_data[INV_DEV_W-1:0];
        CFG_DISTANCE_LIMIT: cfg.distance_limit <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  skc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .down_valid (f_valid),
    .down_ready (f_ready),
    .down_z     (f_z),
    .down_num   (f_num),
    .down_den   (f_den),
    .down_zero  (f_zero),
    .down_truth (f_truth)
  );

  skc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (f_valid),
    .up_ready     (f_ready),
    .up_z         (f_z),
    .up_num       (f_num),
    .up_den       (f_den),
    .up_zero      (f_zero),
    .up_truth     (f_truth),
    .down_valid   (d_valid),
    .down_ready   (d_ready),
    .down_q_milli (d_q_milli),
    .down_q_ratio (d_q_ratio),
    .down_zero    (d_zero),
    .down_truth   (d_truth)
  );

  skc_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (d_valid),
    .up_ready   (d_ready),
    .up_q_milli (d_q_milli),
    .up_q_ratio (d_q_ratio),
    .up_zero    (d_zero),
    .up_truth   (d_truth),
    .result     (result)
  );

`ifndef SYNTH
  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_limit_write: assert property (@(posedge clk) disable iff (rst)
    $past(cfg_wr_en && !rst && cfg_index == CFG_DISTANCE_LIMIT)
      |-> cfg.distance_limit == $past(cfg_data[DIST_W-1:0]))
    else $error("distance limit write lost");

  a_threshold: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.is_skin == (result.data.distance < cfg.distance_limit))
    else $error("skin flag disagrees with distance and limit");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.data.false_positive && result.data.false_negative))
    else $error("false positive and false negative both set");
`endif

endmodule
